[src/obla_pkg.sv]
// Shared types and constants of the order book level aggregator.
package obla_pkg;

	localparam logic [1:0] REQ_ADD     = 2'd0;
	localparam logic [1:0] REQ_SUMMARY = 2'd1;
	localparam logic [1:0] REQ_UPDATE  = 2'd2;
	localparam logic [1:0] REQ_DELETE  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_NO_ORDER = 3'd2;
	localparam logic [2:0] ST_NO_LEVEL = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	localparam logic [2:0] ST_IGNORED  = 3'd5;
	localparam logic [2:0] ST_NO_MAKER = 3'd6;

	localparam logic CFG_REPORT_ASK = 1'b0;
	localparam logic CFG_REPORT_BID = 1'b1;

	typedef enum logic [2:0] {
		OP_IGNORE,
		OP_ORD_ADD,
		OP_ORD_UPD,
		OP_ORD_DEL,
		OP_MKR_UPD,
		OP_MKR_DEL
	} op_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [63:0] order_id;
		logic        side;
		logic [31:0] price;
		logic [31:0] quantity;
		logic [31:0] maker_id;
	} msg_t;

	typedef struct packed {
		logic        is_report;
		logic        report_side;
		logic [31:0] level_price;
		logic [31:0] level_total;
		logic [2:0]  status;
		logic        last;
	} result_t;

	typedef struct packed {
		op_t         op;
		logic [63:0] order_id;
		logic        side;
		logic [31:0] price;
		logic [31:0] quantity;
		logic [31:0] maker_id;
	} cmd_t;

	typedef struct packed {
		logic report_ask_enable;
		logic report_bid_enable;
	} cfg_t;

endpackage

[src/obla_ram.sv]
// Generic simple dual-port RAM with registered read data.
module obla_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/obla_fifo.sv]
// Small register queue used between the stages and at the result side.
module obla_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

[src/obla_front.sv]
// Front end: accepts messages, decodes them into operations and queues them.
module obla_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  obla_pkg::msg_t msg,
	input  logic          cmd_pop,
	output obla_pkg::cmd_t cmd,
	output logic          cmd_empty
);

	obla_pkg::cmd_t dec;
	logic           id_zero;

	assign id_zero = (msg.order_id == 64'd0);

	always_comb begin
		dec.order_id = msg.order_id;
		dec.side     = msg.side;
		dec.price    = msg.price;
		dec.quantity = msg.quantity;
		dec.maker_id = msg.maker_id;
		case (msg.req_type)
			obla_pkg::REQ_DELETE: dec.op = id_zero ? obla_pkg::OP_MKR_DEL : obla_pkg::OP_ORD_DEL;
			obla_pkg::REQ_UPDATE: dec.op = id_zero ? obla_pkg::OP_MKR_UPD : obla_pkg::OP_ORD_UPD;
			obla_pkg::REQ_SUMMARY: dec.op = id_zero ? obla_pkg::OP_MKR_UPD : obla_pkg::OP_ORD_ADD;
			default: dec.op = id_zero ? obla_pkg::OP_IGNORE : obla_pkg::OP_ORD_ADD;
		endcase
	end

	obla_fifo #(
		.W     ($bits(obla_pkg::cmd_t)),
		.DEPTH (2)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (dec),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd),
		.empty  (cmd_empty)
	);

endmodule

[src/obla_back.sv]
// Back end: table searches and updates for one operation, then result beats.
module obla_back #(
	parameter int ORDER_DEPTH     = 1024,
	parameter int LEVELS_PER_SIDE = 256,
	parameter int MAKERS_PER_SIDE = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  obla_pkg::cfg_t    cfg,
	input  logic             cmd_empty,
	input  obla_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	input  logic             pop,
	output logic             empty,
	output obla_pkg::result_t result
);

	localparam int OAW = $clog2(ORDER_DEPTH);
	localparam int OCW = $clog2(ORDER_DEPTH + 1);
	localparam int LIW = $clog2(LEVELS_PER_SIDE);
	localparam int LAW = $clog2(2 * LEVELS_PER_SIDE);
	localparam int LCW = $clog2(LEVELS_PER_SIDE + 1);
	localparam int MIW = $clog2(MAKERS_PER_SIDE);
	localparam int MAW = $clog2(2 * MAKERS_PER_SIDE);
	localparam int MCW = $clog2(MAKERS_PER_SIDE + 1);
	localparam int SIW = (OCW > LCW) ? ((OCW > MCW) ? OCW : MCW) : ((LCW > MCW) ? LCW : MCW);

	typedef enum logic [4:0] {
		S_IDLE, S_RD, S_CK,
		S_A_ORD, S_A_LVL,
		S_U_ORD, S_U_LVL,
		S_D_ORD, S_D_LVL, S_D_MOV,
		S_M_MKR, S_M_CHK, S_M_OLD, S_M_WR, S_M_NEW,
		S_X_MKR, S_X_LVL, S_X_MOV,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {TBL_ORD, TBL_LVL, TBL_MKR} tbl_t;

	function automatic logic [LAW-1:0] lvl_addr(input logic s, input logic [SIW-1:0] i);
		lvl_addr = LAW'(i[LIW-1:0]) + (s ? LAW'(LEVELS_PER_SIDE) : LAW'(0));
	endfunction

	function automatic logic [MAW-1:0] mkr_addr(input logic s, input logic [SIW-1:0] i);
		mkr_addr = MAW'(i[MIW-1:0]) + (s ? MAW'(MAKERS_PER_SIDE) : MAW'(0));
	endfunction

	state_t         state_q, ret_q;
	tbl_t           tbl_q;
	obla_pkg::cmd_t cmd_q;
	logic [63:0]    key_q;
	logic [SIW-1:0] scan_i_q, hidx_q, oidx_q, midx_q;
	logic           hit_q, mhit_q, emit_q;
	logic [127:0]   hdat_q;
	logic [2:0]     st_q;
	logic [1:0]     rep_n_q;
	logic [31:0]    rep_price_q [2];
	logic [31:0]    rep_total_q [2];
	logic [31:0]    oprice_q, oqty_q, mprice_q, mvol_q;
	logic [OCW-1:0] ord_cnt_q;
	logic [LCW-1:0] lvl_cnt_q [2];
	logic [MCW-1:0] mkr_cnt_q [2];

	logic           ord_we, lvl_we, mkr_we;
	logic [OAW-1:0] ord_waddr, ord_raddr;
	logic [LAW-1:0] lvl_waddr, lvl_raddr;
	logic [MAW-1:0] mkr_waddr, mkr_raddr;
	logic [127:0]   ord_wdata, ord_rdata, view;
	logic [63:0]    lvl_wdata, lvl_rdata;
	logic [95:0]    mkr_wdata, mkr_rdata;
	logic [SIW-1:0] limit;
	logic           ord_full, lvl_full, mkr_full, add_ok, rep_en, res_last, res_full;
	obla_pkg::result_t res;

	assign ord_full = (ord_cnt_q == OCW'(ORDER_DEPTH));
	assign lvl_full = (lvl_cnt_q[cmd_q.side] == LCW'(LEVELS_PER_SIDE));
	assign mkr_full = (mkr_cnt_q[cmd_q.side] == MCW'(MAKERS_PER_SIDE));
	assign add_ok   = !(!hit_q && lvl_full) && !ord_full;
	assign rep_en   = cmd_q.side ? cfg.report_bid_enable : cfg.report_ask_enable;
	assign cmd_pop  = (state_q == S_IDLE) && !cmd_empty;

	// Every table is seen through one view: key, price, quantity.
	always_comb begin
		case (tbl_q)
			TBL_ORD: begin
				view  = ord_rdata;
				limit = SIW'(ord_cnt_q);
			end
			TBL_LVL: begin
				view  = {32'd0, lvl_rdata[63:32], lvl_rdata};
				limit = SIW'(lvl_cnt_q[cmd_q.side]);
			end
			default: begin
				view  = {32'd0, mkr_rdata};
				limit = SIW'(mkr_cnt_q[cmd_q.side]);
			end
		endcase
	end

	always_comb begin
		ord_we    = 1'b0;
		lvl_we    = 1'b0;
		mkr_we    = 1'b0;
		ord_waddr = oidx_q[OAW-1:0];
		ord_wdata = {cmd_q.order_id, oprice_q, cmd_q.quantity};
		lvl_waddr = lvl_addr(cmd_q.side, hidx_q);
		lvl_wdata = {hdat_q[63:32], hdat_q[31:0] - mvol_q};
		mkr_waddr = mkr_addr(cmd_q.side, midx_q);
		mkr_wdata = {cmd_q.maker_id, cmd_q.price, cmd_q.quantity};
		ord_raddr = scan_i_q[OAW-1:0];
		lvl_raddr = lvl_addr(cmd_q.side, scan_i_q);
		mkr_raddr = mkr_addr(cmd_q.side, scan_i_q);
		case (state_q)
			S_A_LVL, S_M_NEW: begin
				ord_we    = (state_q == S_A_LVL) && add_ok;
				ord_waddr = ord_cnt_q[OAW-1:0];
				ord_wdata = {cmd_q.order_id, cmd_q.price, cmd_q.quantity};
				lvl_we    = (state_q == S_M_NEW) || add_ok;
				lvl_waddr = hit_q ? lvl_addr(cmd_q.side, hidx_q)
				                  : lvl_addr(cmd_q.side, SIW'(lvl_cnt_q[cmd_q.side]));
				lvl_wdata = {cmd_q.price,
				             hit_q ? hdat_q[31:0] + cmd_q.quantity : cmd_q.quantity};
			end
			S_U_LVL: begin
				ord_we    = 1'b1;
				lvl_we    = hit_q;
				lvl_wdata = {hdat_q[63:32], hdat_q[31:0] + cmd_q.quantity - oqty_q};
			end
			S_D_LVL: begin
				lvl_we    = hit_q;
				lvl_wdata = {hdat_q[63:32], hdat_q[31:0] - oqty_q};
				ord_raddr = OAW'(ord_cnt_q - OCW'(1));
			end
			S_D_MOV: begin
				ord_we    = 1'b1;
				ord_wdata = ord_rdata;
			end
			S_M_OLD: begin
				lvl_we = hit_q;
			end
			S_M_WR: begin
				mkr_we = 1'b1;
			end
			S_X_LVL: begin
				lvl_we    = hit_q;
				mkr_raddr = mkr_addr(cmd_q.side, SIW'(mkr_cnt_q[cmd_q.side] - MCW'(1)));
			end
			S_X_MOV: begin
				mkr_we    = 1'b1;
				mkr_wdata = mkr_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			ret_q          <= S_IDLE;
			tbl_q          <= TBL_ORD;
			cmd_q          <= '0;
			key_q          <= '0;
			scan_i_q       <= '0;
			hidx_q         <= '0;
			oidx_q         <= '0;
			midx_q         <= '0;
			hit_q          <= 1'b0;
			mhit_q         <= 1'b0;
			emit_q         <= 1'b0;
			hdat_q         <= '0;
			st_q           <= obla_pkg::ST_OK;
			rep_n_q        <= '0;
			rep_price_q[0] <= '0;
			rep_price_q[1] <= '0;
			rep_total_q[0] <= '0;
			rep_total_q[1] <= '0;
			oprice_q       <= '0;
			oqty_q         <= '0;
			mprice_q       <= '0;
			mvol_q         <= '0;
			ord_cnt_q      <= '0;
			lvl_cnt_q[0]   <= '0;
			lvl_cnt_q[1]   <= '0;
			mkr_cnt_q[0]   <= '0;
			mkr_cnt_q[1]   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						cmd_q    <= cmd;
						st_q     <= obla_pkg::ST_OK;
						rep_n_q  <= '0;
						emit_q   <= 1'b0;
						scan_i_q <= '0;
						case (cmd.op)
							obla_pkg::OP_ORD_ADD: begin
								tbl_q <= TBL_ORD; key_q <= cmd.order_id;
								ret_q <= S_A_ORD; state_q <= S_RD;
							end
							obla_pkg::OP_ORD_UPD: begin
								tbl_q <= TBL_ORD; key_q <= cmd.order_id;
								ret_q <= S_U_ORD; state_q <= S_RD;
							end
							obla_pkg::OP_ORD_DEL: begin
								tbl_q <= TBL_ORD; key_q <= cmd.order_id;
								ret_q <= S_D_ORD; state_q <= S_RD;
							end
							obla_pkg::OP_MKR_UPD: begin
								tbl_q <= TBL_MKR; key_q <= {32'd0, cmd.maker_id};
								ret_q <= S_M_MKR; state_q <= S_RD;
							end
							obla_pkg::OP_MKR_DEL: begin
								tbl_q <= TBL_MKR; key_q <= {32'd0, cmd.maker_id};
								ret_q <= S_X_MKR; state_q <= S_RD;
							end
							default: begin
								st_q    <= obla_pkg::ST_IGNORED;
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_RD: begin
					if (scan_i_q == limit) begin
						hit_q   <= 1'b0;
						state_q <= ret_q;
					end else begin
						state_q <= S_CK;
					end
				end
				S_CK: begin
					if (view[127:64] == key_q) begin
						hit_q   <= 1'b1;
						hidx_q  <= scan_i_q;
						hdat_q  <= view;
						state_q <= ret_q;
					end else begin
						scan_i_q <= scan_i_q + SIW'(1);
						state_q  <= S_RD;
					end
				end
				S_A_ORD: begin
					if (hit_q) begin
						st_q    <= obla_pkg::ST_DUP;
						state_q <= S_EMIT;
					end else begin
						tbl_q <= TBL_LVL; key_q <= {32'd0, cmd_q.price}; scan_i_q <= '0;
						ret_q <= S_A_LVL; state_q <= S_RD;
					end
				end
				S_A_LVL: begin
					if (add_ok) begin
						ord_cnt_q <= ord_cnt_q + OCW'(1);
						if (!hit_q) begin
							lvl_cnt_q[cmd_q.side] <= lvl_cnt_q[cmd_q.side] + LCW'(1);
						end
					end else begin
						st_q <= obla_pkg::ST_FULL;
					end
					state_q <= S_EMIT;
				end
				S_U_ORD, S_D_ORD: begin
					if (!hit_q) begin
						st_q    <= obla_pkg::ST_NO_ORDER;
						state_q <= S_EMIT;
					end else begin
						oidx_q   <= hidx_q;
						oprice_q <= hdat_q[63:32];
						oqty_q   <= hdat_q[31:0];
						tbl_q    <= TBL_LVL; key_q <= {32'd0, hdat_q[63:32]}; scan_i_q <= '0;
						ret_q    <= (state_q == S_U_ORD) ? S_U_LVL : S_D_LVL;
						state_q  <= S_RD;
					end
				end
				S_U_LVL: begin
					if (!hit_q) begin
						st_q <= obla_pkg::ST_NO_LEVEL;
					end
					state_q <= S_EMIT;
				end
				S_D_LVL: begin
					if (!hit_q) begin
						st_q <= obla_pkg::ST_NO_LEVEL;
					end
					state_q <= S_D_MOV;
				end
				S_D_MOV: begin
					ord_cnt_q <= ord_cnt_q - OCW'(1);
					state_q   <= S_EMIT;
				end
				S_M_MKR: begin
					mhit_q   <= hit_q;
					midx_q   <= hidx_q;
					mprice_q <= hdat_q[63:32];
					mvol_q   <= hdat_q[31:0];
					tbl_q    <= TBL_LVL; key_q <= {32'd0, cmd_q.price}; scan_i_q <= '0;
					ret_q    <= S_M_CHK; state_q <= S_RD;
				end
				S_M_CHK: begin
					if ((!hit_q && lvl_full) || (!mhit_q && mkr_full)) begin
						st_q    <= obla_pkg::ST_FULL;
						state_q <= S_EMIT;
					end else if (!mhit_q) begin
						midx_q                <= SIW'(mkr_cnt_q[cmd_q.side]);
						mkr_cnt_q[cmd_q.side] <= mkr_cnt_q[cmd_q.side] + MCW'(1);
						state_q               <= S_M_WR;
					end else begin
						tbl_q <= TBL_LVL; key_q <= {32'd0, mprice_q}; scan_i_q <= '0;
						ret_q <= S_M_OLD; state_q <= S_RD;
					end
				end
				S_M_OLD, S_X_LVL: begin
					if (hit_q) begin
						if (rep_en) begin
							rep_price_q[rep_n_q[0]] <= lvl_wdata[63:32];
							rep_total_q[rep_n_q[0]] <= lvl_wdata[31:0];
							rep_n_q                 <= rep_n_q + 2'd1;
						end
					end else begin
						st_q <= obla_pkg::ST_NO_LEVEL;
					end
					state_q <= (state_q == S_M_OLD) ? S_M_WR : S_X_MOV;
				end
				S_M_WR: begin
					tbl_q <= TBL_LVL; key_q <= {32'd0, cmd_q.price}; scan_i_q <= '0;
					ret_q <= S_M_NEW; state_q <= S_RD;
				end
				S_M_NEW: begin
					if (!hit_q) begin
						lvl_cnt_q[cmd_q.side] <= lvl_cnt_q[cmd_q.side] + LCW'(1);
					end
					if (rep_en) begin
						rep_price_q[rep_n_q[0]] <= lvl_wdata[63:32];
						rep_total_q[rep_n_q[0]] <= lvl_wdata[31:0];
						rep_n_q                 <= rep_n_q + 2'd1;
					end
					state_q <= S_EMIT;
				end
				S_X_MKR: begin
					if (!hit_q) begin
						st_q    <= obla_pkg::ST_NO_MAKER;
						state_q <= S_EMIT;
					end else begin
						midx_q   <= hidx_q;
						mprice_q <= hdat_q[63:32];
						mvol_q   <= hdat_q[31:0];
						tbl_q    <= TBL_LVL; key_q <= {32'd0, hdat_q[63:32]}; scan_i_q <= '0;
						ret_q    <= S_X_LVL; state_q <= S_RD;
					end
				end
				S_X_MOV: begin
					mkr_cnt_q[cmd_q.side] <= mkr_cnt_q[cmd_q.side] - MCW'(1);
					state_q               <= S_EMIT;
				end
				S_EMIT: begin
					if (!res_full) begin
						if (res_last) begin
							state_q <= S_IDLE;
						end else begin
							emit_q <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_last = (rep_n_q == 2'd0) || ({1'b0, emit_q} == (rep_n_q - 2'd1));

	always_comb begin
		res.is_report   = (rep_n_q != 2'd0);
		res.report_side = res.is_report ? cmd_q.side : 1'b0;
		res.level_price = res.is_report ? rep_price_q[emit_q] : 32'd0;
		res.level_total = res.is_report ? rep_total_q[emit_q] : 32'd0;
		res.status      = res_last ? st_q : obla_pkg::ST_OK;
		res.last        = res_last;
	end

	obla_ram #(.WIDTH(128), .DEPTH(ORDER_DEPTH)) u_ord_ram (
		.clk (clk), .we (ord_we), .waddr (ord_waddr), .wdata (ord_wdata),
		.raddr (ord_raddr), .rdata (ord_rdata)
	);

	obla_ram #(.WIDTH(64), .DEPTH(2 * LEVELS_PER_SIDE)) u_lvl_ram (
		.clk (clk), .we (lvl_we), .waddr (lvl_waddr), .wdata (lvl_wdata),
		.raddr (lvl_raddr), .rdata (lvl_rdata)
	);

	obla_ram #(.WIDTH(96), .DEPTH(2 * MAKERS_PER_SIDE)) u_mkr_ram (
		.clk (clk), .we (mkr_we), .waddr (mkr_waddr), .wdata (mkr_wdata),
		.raddr (mkr_raddr), .rdata (mkr_rdata)
	);

	obla_fifo #(
		.W     ($bits(obla_pkg::result_t)),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (state_q == S_EMIT),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

[src/order_book_level_aggregator_core.sv]
// Top level of the order book level aggregator: config registers, front and back.
//
//  Channel   Handshake            Payload            Notes
//  message   push / full          msg (msg_t)        one beat per book message
//  result    empty / pop          result (result_t)  one or two beats, last marks end
//  config    cfg_write            cfg_index/cfg_data report enables, ask and bid
//
// A message's searches walk the stored entries one by one, each read in S_RD and
// compared in S_CK, ahead of the bookkeeping states. The searches run over the
// single read port of each of the order, level and maker RAMs; tables are kept packed
// by a fill count, so only occupied entries are visited and no clearing is needed.
// Reset is asynchronous and active low and leaves all tables empty. A two-beat
// queue sits on each side of the back end, so the front keeps taking messages
// while the back searches, and the back stalls only when the result queue is full.
module order_book_level_aggregator_core #(
	parameter int ORDER_DEPTH     = 1024,
	parameter int LEVELS_PER_SIDE = 256,
	parameter int MAKERS_PER_SIDE = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  obla_pkg::msg_t     msg,
	output logic              empty,
	input  logic              pop,
	output obla_pkg::result_t  result,
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [0:0]        cfg_data
);

	obla_pkg::cfg_t cfg_q;
	obla_pkg::cmd_t cmd;
	logic           cmd_empty, cmd_pop;

	// Report enables; the user must write them only while the block is idle, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				obla_pkg::CFG_REPORT_ASK: cfg_q.report_ask_enable <= cfg_data[0];
				obla_pkg::CFG_REPORT_BID: cfg_q.report_bid_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The front decodes each message into an operation and queues it.
	obla_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.msg       (msg),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.cmd_empty (cmd_empty)
	);

	// The back walks the tables, applies the change and emits the result beats.
	obla_back #(
		.ORDER_DEPTH     (ORDER_DEPTH),
		.LEVELS_PER_SIDE (LEVELS_PER_SIDE),
		.MAKERS_PER_SIDE (MAKERS_PER_SIDE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_empty (cmd_empty),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

[src/obla_checker.sv]
// Port checker for the order book level aggregator and its bind.
module obla_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input obla_pkg::result_t result
);

	a_nonlast_is_report: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.last) |-> (result.is_report && result.status == obla_pkg::ST_OK))
		else $error("non-final result beat is not a clean report");

	a_status_only_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.is_report) |->
		(result.last && result.level_price == 32'd0 && result.level_total == 32'd0 &&
		 !result.report_side))
		else $error("status-only beat carries level data");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.status <= obla_pkg::ST_NO_MAKER))
		else $error("status code out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result beat changed");

endmodule

bind order_book_level_aggregator_core obla_checker u_obla_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
